### src/ithp_pkg.sv
// ----------------------------------------------------------------------------
// ithp_pkg
// Types and constants for the Ethernet/IPv4/TCP/UDP header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ithp_pkg;

    localparam logic [15:0] MAX_CAPTURE_BYTES = 16'd65535;

    localparam logic [15:0] ETH_LEN         = 16'd14;
    localparam logic [15:0] IPV4_ETHERTYPE  = 16'h0800;
    localparam logic [15:0] MIN_IP_HDR      = 16'd20;
    localparam logic [15:0] UDP_HDR_LEN     = 16'd8;
    localparam logic [15:0] IP_ADDR_END     = 16'd34;
    localparam logic [15:0] IDX_ETYPE_HI    = 16'd12;
    localparam logic [15:0] IDX_ETYPE_LO    = 16'd13;
    localparam logic [15:0] IDX_IHL         = 16'd14;
    localparam logic [15:0] IDX_PROTO       = 16'd23;
    localparam logic [15:0] IDX_SRC_FIRST   = 16'd26;
    localparam logic [15:0] IDX_SRC_LAST    = 16'd29;
    localparam logic [15:0] IDX_DST_FIRST   = 16'd30;
    localparam logic [15:0] IDX_DST_LAST    = 16'd33;
    localparam logic [15:0] L4_SPORT_LAST   = 16'd1;
    localparam logic [15:0] L4_DPORT_LAST   = 16'd3;
    localparam logic [15:0] L4_TCP_OFF_IDX  = 16'd12;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [1:0] ST_PARSED   = 2'd0;
    localparam logic [1:0] ST_NOT_IPV4 = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;

    localparam logic [1:0] L4_OTHER = 2'd0;
    localparam logic [1:0] L4_TCP   = 2'd1;
    localparam logic [1:0] L4_UDP   = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  proto_num;
        logic [5:0]  ip_hdr_bytes;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [1:0]  l4_kind;
        logic [15:0] l4_sport;
        logic [15:0] l4_dport;
        logic [5:0]  l4_hdr_bytes;
        logic [15:0] pld_bytes;
    } t_out_item;

    typedef struct packed {
        logic [15:0] byte_count;
        logic [15:0] ether_type;
        logic [3:0]  ihl_words;
        logic [7:0]  proto_seen;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [3:0]  tcp_offset_words;
    } t_frame_state;

endpackage

`default_nettype wire

### src/ithp_frame_state.sv
// ----------------------------------------------------------------------------
// ithp_frame_state
// Per-frame byte counter and header field capture registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ithp_frame_state (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_en,
    input  ithp_pkg::t_in_item     i_item,
    output ithp_pkg::t_frame_state o_next
);

    ithp_pkg::t_frame_state r_state;
    ithp_pkg::t_frame_state n_state;

    logic [15:0] idx;
    logic [15:0] l4_off;
    logic [15:0] l4_rel;
    logic [7:0]  b;

    assign idx    = r_state.byte_count;
    assign b      = i_item.data_byte;
    assign l4_off = ithp_pkg::ETH_LEN + {10'd0, r_state.ihl_words, 2'b00};
    assign l4_rel = idx - l4_off;

    always_comb begin
        n_state = r_state;
        if (idx < ithp_pkg::MAX_CAPTURE_BYTES) begin
            priority if (idx == ithp_pkg::IDX_ETYPE_HI || idx == ithp_pkg::IDX_ETYPE_LO) begin
                n_state.ether_type = {r_state.ether_type[7:0], b};
            end else if (idx == ithp_pkg::IDX_IHL) begin
                n_state.ihl_words = b[3:0];
            end else if (idx == ithp_pkg::IDX_PROTO) begin
                n_state.proto_seen = b;
            end else if (idx >= ithp_pkg::IDX_SRC_FIRST && idx <= ithp_pkg::IDX_SRC_LAST) begin
                n_state.source_addr = {r_state.source_addr[23:0], b};
            end else if (idx >= ithp_pkg::IDX_DST_FIRST && idx <= ithp_pkg::IDX_DST_LAST) begin
                n_state.dest_addr = {r_state.dest_addr[23:0], b};
            end else begin
            end

            if (idx >= ithp_pkg::IP_ADDR_END && idx >= l4_off) begin
                priority if (l4_rel <= ithp_pkg::L4_SPORT_LAST) begin
                    n_state.source_port = {r_state.source_port[7:0], b};
                end else if (l4_rel <= ithp_pkg::L4_DPORT_LAST) begin
                    n_state.dest_port = {r_state.dest_port[7:0], b};
                end else if (l4_rel == ithp_pkg::L4_TCP_OFF_IDX) begin
                    n_state.tcp_offset_words = b[7:4];
                end else begin
                end
            end
            n_state.byte_count = idx + 16'd1;
        end
    end

    assign o_next = n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_en) begin
            r_state <= i_item.last ? '0 : n_state;
        end
    end

endmodule

`default_nettype wire

### src/ithp_classify.sv
// ----------------------------------------------------------------------------
// ithp_classify
// Frame status and result fields from the captured header state.
// ----------------------------------------------------------------------------
`default_nettype none

module ithp_classify (
    input  ithp_pkg::t_frame_state i_state,
    output ithp_pkg::t_out_item    o_item
);

    logic [16:0] cap;
    logic [5:0]  hl;
    logic [5:0]  tcp_hl;
    logic [16:0] l4_off;
    logic [16:0] hdr_end;
    logic [5:0]  l4_len;
    logic [1:0]  kind;
    logic [1:0]  status;

    assign cap     = {1'b0, i_state.byte_count};
    assign hl      = {i_state.ihl_words, 2'b00};
    assign tcp_hl  = {i_state.tcp_offset_words, 2'b00};
    assign l4_off  = {1'b0, ithp_pkg::ETH_LEN} + {11'd0, hl};
    assign hdr_end = l4_off + {11'd0, l4_len};

    always_comb begin
        unique case (i_state.proto_seen)
            ithp_pkg::PROTO_TCP: begin
                kind   = ithp_pkg::L4_TCP;
                l4_len = tcp_hl;
            end
            ithp_pkg::PROTO_UDP: begin
                kind   = ithp_pkg::L4_UDP;
                l4_len = ithp_pkg::UDP_HDR_LEN[5:0];
            end
            default: begin
                kind   = ithp_pkg::L4_OTHER;
                l4_len = 6'd0;
            end
        endcase
    end

    always_comb begin
        priority if (cap < {1'b0, ithp_pkg::ETH_LEN}) begin
            status = ithp_pkg::ST_BAD_LEN;
        end else if (i_state.ether_type != ithp_pkg::IPV4_ETHERTYPE) begin
            status = ithp_pkg::ST_NOT_IPV4;
        end else if (cap < {1'b0, ithp_pkg::IP_ADDR_END}) begin
            status = ithp_pkg::ST_BAD_LEN;
        end else if ({10'd0, hl} < ithp_pkg::MIN_IP_HDR) begin
            status = ithp_pkg::ST_BAD_LEN;
        end else if (cap < l4_off) begin
            status = ithp_pkg::ST_BAD_LEN;
        end else if (kind == ithp_pkg::L4_TCP &&
                     (cap < l4_off + {1'b0, ithp_pkg::MIN_IP_HDR} ||
                      {10'd0, tcp_hl} < ithp_pkg::MIN_IP_HDR || cap < hdr_end)) begin
            status = ithp_pkg::ST_BAD_LEN;
        end else if (kind == ithp_pkg::L4_UDP && cap < hdr_end) begin
            status = ithp_pkg::ST_BAD_LEN;
        end else begin
            status = ithp_pkg::ST_PARSED;
        end
    end

    always_comb begin
        o_item        = '0;
        o_item.status = status;
        if (status == ithp_pkg::ST_PARSED) begin
            o_item.proto_num    = i_state.proto_seen;
            o_item.ip_hdr_bytes = hl;
            o_item.src_ip       = i_state.source_addr;
            o_item.dst_ip       = i_state.dest_addr;
            if (kind != ithp_pkg::L4_OTHER) begin
                o_item.l4_kind      = kind;
                o_item.l4_sport     = i_state.source_port;
                o_item.l4_dport     = i_state.dest_port;
                o_item.l4_hdr_bytes = l4_len;
                o_item.pld_bytes    = (cap > hdr_end) ? 16'(cap - hdr_end) : 16'd0;
            end
        end
    end

endmodule

`default_nettype wire

### src/ipv4_tcp_udp_header_parser_unit.sv
// ----------------------------------------------------------------------------
// ipv4_tcp_udp_header_parser_unit
// Result is registered: valid in the cycle after the frame's last byte advances.
// Throughput: one byte per cycle; a last byte waits only while a result is stalled.
// Reset clears the byte count, all captured fields and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_tcp_udp_header_parser_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  ithp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output ithp_pkg::t_out_item o_out_item
);

    logic                   r_in_valid;
    ithp_pkg::t_in_item     r_in_item;
    logic                   r_out_valid;
    ithp_pkg::t_out_item    r_out_item;

    logic                   out_free;
    logic                   advance;
    ithp_pkg::t_frame_state next_state;
    ithp_pkg::t_out_item    result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!r_in_item.last || out_free);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
    end

    ithp_frame_state u_frame_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_in_item),
        .o_next  (next_state)
    );

    ithp_classify u_classify (
        .i_state (next_state),
        .o_item  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_item.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_item.last) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_item.last) |=> o_out_valid)
        else $error("last byte did not produce a result");

    a_fail_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != ithp_pkg::ST_PARSED) |->
        (o_out_item.proto_num == 8'd0 && o_out_item.src_ip == 32'd0 &&
         o_out_item.dst_ip == 32'd0 && o_out_item.l4_kind == ithp_pkg::L4_OTHER &&
         o_out_item.pld_bytes == 16'd0))
        else $error("failed frame carries nonzero fields");

    a_other_no_ports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.l4_kind == ithp_pkg::L4_OTHER) |->
        (o_out_item.l4_sport == 16'd0 && o_out_item.l4_dport == 16'd0 &&
         o_out_item.l4_hdr_bytes == 6'd0))
        else $error("non-TCP/UDP result carries port fields");

    a_tcp_hdr_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.l4_kind == ithp_pkg::L4_TCP) |->
        (o_out_item.status == ithp_pkg::ST_PARSED && o_out_item.l4_hdr_bytes >= 6'd20))
        else $error("TCP result with short header length");

endmodule

`default_nettype wire
